// ----- rtl/stvg_pkg.sv -----
// package for the side-scan tvg pixel quantizer
// shared types, constants and the log2 table function; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package stvg_pkg;

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [1:0] REG_LOG_GAIN      = 2'd0;
  localparam logic [1:0] REG_LINEAR_GAIN   = 2'd1;
  localparam logic [1:0] REG_CONSTANT_GAIN = 2'd2;
  localparam logic [1:0] REG_INVERSE_SCALE = 2'd3;

  localparam logic [15:0] LOG_GAIN_RST      = 16'd10240;
  localparam logic [15:0] LINEAR_GAIN_RST   = 16'd5120;
  localparam logic [15:0] CONSTANT_GAIN_RST = 16'd256;
  localparam logic [15:0] INVERSE_SCALE_RST = 16'd655;

  localparam logic [39:0] RANGE_MAX = {40{1'b1}};
  localparam logic [16:0] LN2_Q16   = 17'd45426;
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  // decoded work item passed from front to back
  typedef struct packed {
    logic [39:0] range;
    logic [15:0] sample;
    logic [5:0]  shift;
    logic [19:0] index;
    logic        last;
  } work_t;

  // log2(x) for x in [1,2), Q16 in and out, by repeated squaring (elaboration only)
  function automatic logic [16:0] log2_unit(input logic [17:0] x_in);
    logic [35:0] x;
    logic [16:0] res;
    x = {18'd0, x_in};
    res = '0;
    if (x_in >= 18'h20000) begin
      res = 17'h10000;
    end else begin
      for (int k = 1; k <= 16; k++) begin
        x = (x * x) >> 16;
        if (x >= 36'h20000) begin
          x = x >> 1;
          res = res | (17'd1 << (16 - k));
        end
      end
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/stvg_front.sv -----
// front part: accepts header and sample words, keeps line state and range
// depends on stvg_pkg
`timescale 1ns / 1ps
`default_nettype none
module stvg_front
  import stvg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation_i,
  input  logic [15:0] sample_value_i,
  input  logic [19:0] sample_count_i,
  input  logic [31:0] interval_ns_i,
  input  logic [5:0]  weight_exponent_i,
  input  logic        is_port_i,
  output logic        push_o,
  output work_t       work_o,
  input  logic        full_i
);

  typedef enum logic [2:0] {F_IDLE, F_MUL, F_RED, F_MUL2, F_RED2} fstate_e;

  // step = interval * 49152000 / 1e9 = interval * 768 / 15625
  // interval = 15625 * qa + ra, step = 768 * qa + (768 * ra) / 15625
  // each divide by 15625 is a reciprocal multiply and one correcting compare
  localparam logic [31:0] RECIP   = 32'd2251799813; // floor(2^45 / 15625)
  localparam logic [31:0] DIVISOR = 32'd15625;

  fstate_e     state_q;
  logic [19:0] len_q, pos_q;
  logic [39:0] step_q, range_q;
  logic [5:0]  shift_q;
  logic        port_q;
  logic [63:0] prod_q;
  logic [31:0] interval_q;
  logic [18:0] qa_q;
  logic [31:0] y_q;
  logic [39:0] range_sum;
  logic        sum_ovf;
  logic        take;
  logic [18:0] qest;
  logic [31:0] div_n, rem_c, rem_fix;
  logic        rem_hi;

  assign qest    = prod_q[63:45];
  assign div_n   = (state_q == F_RED2) ? y_q : interval_q;
  assign rem_c   = div_n - {13'd0, qest} * DIVISOR;
  assign rem_hi  = (rem_c >= DIVISOR);
  assign rem_fix = rem_hi ? rem_c - DIVISOR : rem_c;

  assign take = in_valid && in_ready;
  assign in_ready = (state_q == F_IDLE) && !full_i;
  assign {sum_ovf, range_sum} = {1'b0, range_q} + {1'b0, step_q};

  assign push_o = take && (operation_i == OP_SAMPLE) && (pos_q < len_q);
  always_comb begin
    work_o.range  = (range_q < {23'd0, ONE_Q16}) ? {23'd0, ONE_Q16} : range_q;
    work_o.sample = sample_value_i;
    work_o.shift  = shift_q;
    work_o.index  = port_q ? (len_q - 20'd1 - pos_q) : pos_q;
    work_o.last   = (pos_q == len_q - 20'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      len_q      <= '0;
      pos_q      <= '0;
      step_q     <= '0;
      range_q    <= '0;
      shift_q    <= '0;
      port_q     <= 1'b0;
      interval_q <= '0;
      prod_q     <= '0;
      qa_q       <= '0;
      y_q        <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (take) begin
            if (operation_i == OP_HEADER) begin
              len_q      <= sample_count_i;
              pos_q      <= '0;
              range_q    <= '0;
              shift_q    <= weight_exponent_i;
              port_q     <= is_port_i;
              interval_q <= interval_ns_i;
              state_q    <= F_MUL;
            end else if (push_o) begin
              pos_q   <= pos_q + 20'd1;
              range_q <= sum_ovf ? RANGE_MAX : range_sum;
            end
          end
        end
        F_MUL: begin
          prod_q  <= {32'd0, interval_q} * {32'd0, RECIP};
          state_q <= F_RED;
        end
        F_RED: begin
          qa_q    <= qest + {18'd0, rem_hi};
          y_q     <= (rem_fix << 9) + (rem_fix << 8);
          state_q <= F_MUL2;
        end
        F_MUL2: begin
          prod_q  <= {32'd0, y_q} * {32'd0, RECIP};
          state_q <= F_RED2;
        end
        F_RED2: begin
          step_q  <= 40'({qa_q, 9'd0}) + 40'({qa_q, 8'd0}) + 40'(qest) + 40'(rem_hi);
          state_q <= F_IDLE;
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/stvg_queue.sv -----
// two-entry queue between front and back
// depends on stvg_pkg
`timescale 1ns / 1ps
`default_nettype none
module stvg_queue
  import stvg_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  output logic  full_o,
  output logic  valid_o,
  input  logic  pop_i,
  output work_t data_o
);

  work_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o |-> !pop_i) else $error("queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count");
`endif

endmodule
`default_nettype wire

// ----- rtl/stvg_back.sv -----
// back part: log, gain and quantize sequencer with output register
// depends on stvg_pkg
`timescale 1ns / 1ps
`default_nettype none
module stvg_back
  import stvg_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] log_gain_i,
  input  logic [15:0] linear_gain_i,
  input  logic [15:0] constant_gain_i,
  input  logic [15:0] inverse_scale_i,
  input  logic        valid_i,
  input  work_t       work_i,
  output logic        pop_o,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_value_o,
  output logic [19:0] pixel_index_o,
  output logic        last_of_line_o
);

  localparam int TW = $clog2(LOG_TABLE_ENTRIES);

  typedef enum logic [3:0] {
    B_IDLE, B_MSB, B_LUT, B_INTERP, B_LN, B_G1, B_G2, B_Q1, B_Q2, B_Q3, B_OUT
  } bstate_e;

  function automatic logic [16:0] tab(input logic [TW:0] i);
    logic [17:0] x;
    x = 18'(ONE_Q16) + 18'((64'(i) << 16) / LOG_TABLE_ENTRIES);
    return log2_unit(x);
  endfunction

  bstate_e     state_q;
  work_t       w_q;
  logic [5:0]  msb_q;
  logic [39:0] norm_q;
  logic [16:0] ta_q, tb_q;
  logic [15:0] pfrac_q;
  logic [22:0] l2_q;
  logic [39:0] ln_q;
  logic [63:0] gain_q;
  logic [31:0] a_q;
  logic [63:0] p0_q, p1_q;
  logic [7:0]  pix_q;

  logic [5:0]  msb_c;
  logic [TW+16:0] pos_c;
  logic [TW-1:0]  idx_c;
  logic [127:0]   full_c;
  logic [63:0]    sh_c;
  logic [7:0]     pix_c;
  logic [6:0]     sh_amt;
  logic           out_load;
  logic [16:0]    log_tab [LOG_TABLE_ENTRIES+1];

  // constant log2 fraction table
  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
    assign log_tab[g] = tab((TW+1)'(g));
  end

  always_comb begin
    msb_c = 6'd16;
    for (int b = 17; b < 40; b++) begin
      if (w_q.range[b]) msb_c = 6'(b);
    end
  end

  assign pos_c = (TW+17)'(norm_q[15:0]) * (TW+17)'(LOG_TABLE_ENTRIES);
  assign idx_c = pos_c[TW+15:16];

  // full 128-bit product assembled from two partial products
  assign full_c = {64'd0, p0_q} + {32'd0, p1_q, 32'd0};
  assign sh_amt = 7'(7'sd32 + {{1{w_q.shift[5]}}, w_q.shift});

  always_comb begin
    sh_c = (full_c >> sh_amt) > 128'd255 ? 64'd255 : 64'(full_c >> sh_amt);
    pix_c = sh_c[7:0];
  end

  assign pop_o = (state_q == B_IDLE) && valid_i;
  assign out_load = (state_q == B_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state_q)
        B_IDLE: if (valid_i) begin
          w_q     <= work_i;
          state_q <= B_MSB;
        end
        B_MSB: begin
          msb_q   <= msb_c;
          norm_q  <= w_q.range >> (msb_c - 6'd16);
          state_q <= B_LUT;
        end
        B_LUT: begin
          ta_q    <= log_tab[{1'b0, idx_c}];
          tb_q    <= log_tab[{1'b0, idx_c} + (TW+1)'(1)];
          pfrac_q <= pos_c[15:0];
          state_q <= B_INTERP;
        end
        B_INTERP: begin
          l2_q <= 23'({msb_q - 6'd16, 16'd0}) + 23'(ta_q)
                + 23'((33'(tb_q - ta_q) * 33'(pfrac_q)) >> 16);
          state_q <= B_LN;
        end
        B_LN: begin
          ln_q    <= 40'((64'(l2_q) * 64'(LN2_Q16)) >> 16);
          state_q <= B_G1;
        end
        B_G1: begin
          gain_q  <= 64'((64'(log_gain_i) * 64'(ln_q)) >> 8)
                   + {40'd0, constant_gain_i, 8'd0};
          a_q     <= {16'd0, w_q.sample} * {16'd0, inverse_scale_i};
          state_q <= B_G2;
        end
        B_G2: begin
          gain_q  <= gain_q + 64'((64'(linear_gain_i) * 64'(w_q.range)) >> 8);
          state_q <= B_Q1;
        end
        B_Q1: begin
          p0_q    <= {32'd0, a_q} * {32'd0, gain_q[31:0]};
          p1_q    <= {32'd0, a_q} * {32'd0, gain_q[63:32]};
          state_q <= B_Q2;
        end
        B_Q2: begin
          pix_q   <= (w_q.sample[15] || w_q.sample == 16'd0) ? 8'd0 : pix_c;
          state_q <= B_Q3;
        end
        B_Q3: state_q <= B_OUT;
        B_OUT: if (out_load) begin
          pixel_value_o  <= pix_q;
          pixel_index_o  <= w_q.index;
          last_of_line_o <= w_q.last;
          state_q        <= B_IDLE;
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q == B_MSB) else $error("pop outside idle");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pixel_value_o))
    else $error("output word dropped");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid) else $error("output word not raised");
`endif

endmodule
`default_nettype wire

// ----- rtl/sidescan_tvg_pixel_quantizer.sv -----
// top level of the side-scan tvg pixel quantizer
// depends on stvg_pkg, stvg_front, stvg_queue, stvg_back
//
// channel | handshake              | word
// in      | in_valid / in_ready    | operation, sample, header fields
// out     | out_valid / out_ready  | pixel value, index, last flag
// cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// a sample holds the back sequencer through msb search, table,
// interpolate, ln, two gain steps, split multiply, saturate and output; its pixel
// word is registered in the output stage and held there until out_ready takes it.
// a header holds in_ready low while the front forms the range step.
// reset clears all line state and restores the gain registers.
// the front stalls on a full queue and while it forms the range step, the back only on a held output word.
`timescale 1ns / 1ps
`default_nettype none
module sidescan_tvg_pixel_quantizer
  import stvg_pkg::*;
#(
  parameter int LOG_TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation_i,
  input  logic [15:0] sample_value_i,
  input  logic [19:0] sample_count_i,
  input  logic [31:0] interval_ns_i,
  input  logic [5:0]  weight_exponent_i,
  input  logic        is_port_i,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  pixel_value_o,
  output logic [19:0] pixel_index_o,
  output logic        last_of_line_o,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] log_gain_q, linear_gain_q, constant_gain_q, inverse_scale_q;
  logic        push, full, qvalid, pop;
  work_t       wdata, qdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_gain_q      <= LOG_GAIN_RST;
      linear_gain_q   <= LINEAR_GAIN_RST;
      constant_gain_q <= CONSTANT_GAIN_RST;
      inverse_scale_q <= INVERSE_SCALE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOG_GAIN:      log_gain_q      <= cfg_data;
        REG_LINEAR_GAIN:   linear_gain_q   <= cfg_data;
        REG_CONSTANT_GAIN: constant_gain_q <= cfg_data;
        REG_INVERSE_SCALE: inverse_scale_q <= cfg_data;
        default: ;
      endcase
    end
  end

  stvg_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .operation_i, .sample_value_i,
    .sample_count_i, .interval_ns_i, .weight_exponent_i, .is_port_i,
    .push_o(push), .work_o(wdata), .full_i(full)
  );

  stvg_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(wdata), .full_o(full),
    .valid_o(qvalid), .pop_i(pop), .data_o(qdata)
  );

  stvg_back #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .log_gain_i(log_gain_q), .linear_gain_i(linear_gain_q),
    .constant_gain_i(constant_gain_q), .inverse_scale_i(inverse_scale_q),
    .valid_i(qvalid), .work_i(qdata), .pop_o(pop),
    .out_valid, .out_ready, .pixel_value_o, .pixel_index_o, .last_of_line_o
  );

endmodule
`default_nettype wire
